/* hdl/dll_name_lookalike_check_unit_assert.svh */
// Assertion macros for the lookalike check unit.
`ifndef DLL_NAME_LOOKALIKE_CHECK_UNIT_ASSERT_SVH
`define DLL_NAME_LOOKALIKE_CHECK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Holds at every clock edge outside reset.
`define LKC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define LKC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LKC_ASSERT(label, expr, msg)
`define LKC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* hdl/lkc_pkg.sv */
// Types, constants and reference name table for the lookalike check unit.
package lkc_pkg;

  localparam int TABLE_NAMES = 12;
  localparam int TABLE_WIDTH = 16;
  localparam int CHAR_W      = 16;
  localparam int COL_W       = 6;   // holds column 0..63
  localparam int ENTRY_W     = 4;   // reference index, also the "none" code

  localparam logic [TABLE_WIDTH*8-1:0] REF_TEXT [TABLE_NAMES] = '{
    "ntdll.dll", "kernel32.dll", "kernelbase.dll", "user32.dll",
    "gdi32.dll", "advapi32.dll", "ole32.dll", "shell32.dll",
    "combase.dll", "msvcrt.dll", "ws2_32.dll", "wininet.dll"
  };

  localparam int REF_LEN [TABLE_NAMES] = '{9, 12, 14, 10, 9, 12, 9, 11, 11, 10, 10, 11};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               load;
    logic               step;
    logic [COL_W-1:0]   col;
    logic               init;
    logic               scan_clear;
    logic               scan_check;
    logic [ENTRY_W-1:0] entry;
    logic               out_load;
  } cmd_t;

  typedef struct packed {
    logic too_long;
    logic found;
    logic out_free;
  } status_t;

  // Character p (0-based) of reference r; zero past its end.
  function automatic logic [CHAR_W-1:0] ref_char(input int r, input int p);
    logic [7:0] b;
    b = 8'h00;
    if (p >= 0 && p < REF_LEN[r]) begin
      b = REF_TEXT[r][8*(REF_LEN[r]-1-p) +: 8];
    end
    return {8'h00, b};
  endfunction

  function automatic logic [1:0] sat3(input logic [2:0] v);
    return (v > 3'd3) ? 2'd3 : v[1:0];
  endfunction

endpackage

/* hdl/lkc_stream_if.sv */
// Valid/ready channel interfaces for characters in and verdicts out.
interface lkc_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] name_char;
  logic        last;
  modport source(output valid, name_char, last, input ready);
  modport sink(input valid, name_char, last, output ready);
endinterface

interface lkc_verdict_if;
  logic       valid;
  logic       ready;
  logic       is_lookalike;
  logic       is_system_name;
  logic [3:0] deciding_entry;
  modport source(output valid, is_lookalike, is_system_name, deciding_entry, input ready);
  modport sink(input valid, is_lookalike, is_system_name, deciding_entry, output ready);
endinterface

/* hdl/lkc_datapath.sv */
// Distance rows, per-name column update lanes, scan result and output register.
module lkc_datapath #(
  parameter int REF_COUNT    = 12,
  parameter int ACTIVE_COUNT = 12,
  parameter int NAME_MAX_LEN = 32,
  parameter int REF_MAX_LEN  = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkc_pkg::cmd_t                     cmd,
  output lkc_pkg::status_t                  sts,
  input  logic [lkc_pkg::CHAR_W-1:0]        name_char,
  lkc_verdict_if.source                     verdict
);

  localparam int ROW_N = REF_MAX_LEN + 1;
  localparam int IDX_W = (ACTIVE_COUNT > 1) ? $clog2(ACTIVE_COUNT) : 1;
  localparam int LEN_W = $clog2(NAME_MAX_LEN + 2);

  logic [lkc_pkg::CHAR_W-1:0] ch;
  logic [LEN_W-1:0]           name_len;
  logic [1:0]                 fin_all [ACTIVE_COUNT];
  logic [1:0]                 fin_sel;

  logic                         pend_lk;
  logic                         pend_sys;
  logic [lkc_pkg::ENTRY_W-1:0]  pend_idx;
  logic                         out_valid;

  // Character register, folded to lower case for A..Z only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (name_char >= 16'h0041 && name_char <= 16'h005A) begin
        ch <= name_char + 16'h0020;
      end else begin
        ch <= name_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      name_len <= '0;
    end else if (cmd.load && name_len <= LEN_W'(NAME_MAX_LEN)) begin
      name_len <= name_len + 1'b1;
    end
  end

  // One lane per reference name; each row rotates once per character.
  for (genvar r = 0; r < ACTIVE_COUNT; r++) begin : g_lane
    localparam int LEN_T = (lkc_pkg::REF_LEN[r] < lkc_pkg::TABLE_WIDTH) ?
                           lkc_pkg::REF_LEN[r] : lkc_pkg::TABLE_WIDTH;
    localparam int LEN_R = (LEN_T < REF_MAX_LEN) ? LEN_T : REF_MAX_LEN;

    logic [1:0] row [ROW_N];
    logic [1:0] diag;
    logic [1:0] left;
    logic [1:0] fin;
    logic [1:0] head;
    logic [1:0] nv;
    logic [2:0] up;
    logic [2:0] lf;
    logic [2:0] dg;
    logic [2:0] best;
    logic       cost;

    always_comb begin
      head = row[0];
      up   = {1'b0, head} + 3'd1;
      lf   = {1'b0, left} + 3'd1;
      cost = (lkc_pkg::ref_char(r, int'(cmd.col) - 1) != ch);
      dg   = {1'b0, diag} + {2'b00, cost};
      best = up;
      if (lf < best) best = lf;
      if (dg < best) best = dg;
      if (cmd.col == '0) begin
        nv = lkc_pkg::sat3(up);
      end else if (cmd.col <= lkc_pkg::COL_W'(LEN_R)) begin
        nv = lkc_pkg::sat3(best);
      end else begin
        nv = head;
      end
    end

    always_ff @(posedge clk) begin
      if (rst || cmd.init) begin
        for (int k = 0; k < ROW_N; k++) begin
          row[k] <= (k > 3) ? 2'd3 : 2'(k);
        end
      end else if (cmd.step) begin
        for (int k = 0; k < ROW_N - 1; k++) begin
          row[k] <= row[k+1];
        end
        row[ROW_N-1] <= nv;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.step) begin
        diag <= head;
        left <= nv;
        if (cmd.col == lkc_pkg::COL_W'(LEN_R)) begin
          fin <= nv;
        end
      end
    end

    assign fin_all[r] = fin;
  end

  assign fin_sel = fin_all[cmd.entry[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      pend_lk  <= 1'b0;
      pend_sys <= 1'b0;
      pend_idx <= lkc_pkg::ENTRY_W'(REF_COUNT);
    end else if (cmd.scan_check && fin_sel <= 2'd2) begin
      pend_lk  <= (fin_sel != 2'd0);
      pend_sys <= (fin_sel == 2'd0);
      pend_idx <= cmd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      verdict.is_lookalike   <= pend_lk;
      verdict.is_system_name <= pend_sys;
      verdict.deciding_entry <= pend_idx;
    end
  end

  assign verdict.valid = out_valid;

  assign sts.too_long = (name_len > LEN_W'(NAME_MAX_LEN));
  assign sts.found    = (fin_sel <= 2'd2);
  assign sts.out_free = !out_valid || verdict.ready;

endmodule

/* hdl/lkc_controller.sv */
// Sequencer: accepts a character, sweeps the columns, scans names, hands off the verdict.
module lkc_controller #(
  parameter int ACTIVE_COUNT = 12,
  parameter int REF_MAX_LEN  = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  lkc_pkg::status_t  sts,
  output lkc_pkg::cmd_t     cmd
);

  lkc_pkg::state_t               state, state_next;
  logic [lkc_pkg::COL_W-1:0]     col, col_next;
  logic [lkc_pkg::ENTRY_W-1:0]   entry, entry_next;
  logic                          last_q, last_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lkc_pkg::ST_IDLE;
      col    <= '0;
      entry  <= '0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      col    <= col_next;
      entry  <= entry_next;
      last_q <= last_q_next;
    end
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    entry_next     = entry;
    last_q_next    = last_q;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.col        = col;
    cmd.entry      = entry;
    unique case (state)
      lkc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          last_q_next = in_last;
          col_next    = '0;
          state_next  = lkc_pkg::ST_SWEEP;
        end
      end
      lkc_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (col == lkc_pkg::COL_W'(REF_MAX_LEN)) begin
          if (last_q) begin
            cmd.init       = 1'b1;
            cmd.scan_clear = 1'b1;
            entry_next     = '0;
            state_next     = sts.too_long ? lkc_pkg::ST_DONE : lkc_pkg::ST_SCAN;
          end else begin
            state_next = lkc_pkg::ST_IDLE;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      lkc_pkg::ST_SCAN: begin
        cmd.scan_check = 1'b1;
        if (sts.found || entry == lkc_pkg::ENTRY_W'(ACTIVE_COUNT - 1)) begin
          state_next = lkc_pkg::ST_DONE;
        end else begin
          entry_next = entry + 1'b1;
        end
      end
      lkc_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lkc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/dll_name_lookalike_check_unit.sv */
// Top level of the file name lookalike check unit.
// A file name arrives one UTF-16 code unit per transaction on chars, with last set on its
// final unit; A..Z are folded to lower case. Each unit is registered on acceptance and then
// swept through REF_MAX_LEN+1 columns, one column per cycle for all reference names in
// parallel, over the per-name rotating distance rows; the next unit is taken only after the
// sweep ends. On the last unit the reference names are then scanned in order, one per cycle,
// until one is within distance 2 (at most min(REF_COUNT,12) names; skipped for a name over
// NAME_MAX_LEN units), and the verdict is then moved into the output register once that
// register is free. The next name can start while that verdict waits on verdict.
// deciding_entry reads REF_COUNT (low four bits) when no name decided. The distance rows are
// flip-flops reloaded together on reset or init, so no clearing pass follows reset.
module dll_name_lookalike_check_unit #(
  parameter int REF_COUNT    = 12,
  parameter int NAME_MAX_LEN = 32,
  parameter int REF_MAX_LEN  = 14
) (
  input  logic          clk,
  input  logic          rst,
  lkc_char_if.sink      chars,
  lkc_verdict_if.source verdict
);

`include "dll_name_lookalike_check_unit_assert.svh"

  localparam int ACTIVE_COUNT = (REF_COUNT < lkc_pkg::TABLE_NAMES) ?
                                REF_COUNT : lkc_pkg::TABLE_NAMES;

  lkc_pkg::cmd_t    cmd;
  lkc_pkg::status_t sts;

  lkc_controller #(
    .ACTIVE_COUNT (ACTIVE_COUNT),
    .REF_MAX_LEN  (REF_MAX_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_last  (chars.last),
    .in_ready (chars.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkc_datapath #(
    .REF_COUNT    (REF_COUNT),
    .ACTIVE_COUNT (ACTIVE_COUNT),
    .NAME_MAX_LEN (NAME_MAX_LEN),
    .REF_MAX_LEN  (REF_MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .name_char (chars.name_char),
    .verdict   (verdict)
  );

  `LKC_ASSERT(a_no_accept_in_sweep, !(chars.ready && cmd.step), "unit accepted while sweeping")
  `LKC_ASSERT_NEXT(a_accept_starts_sweep, chars.valid && chars.ready, cmd.step && cmd.col == '0, "sweep did not start at column zero")
  `LKC_ASSERT(a_out_load_slot_free, !cmd.out_load || !verdict.valid || verdict.ready, "verdict overwritten before transaction")
  `LKC_ASSERT(a_flags_exclusive, !(verdict.valid && verdict.is_lookalike && verdict.is_system_name), "both verdict flags set")

endmodule
